/* rtl/diwes_pkg.sv */
// shared types and constants of the debounced input word event scanner
`default_nettype none
package diwes_pkg;

   // word layout
   localparam int WORD_BITS     = 16;
   localparam int CONTACT_COUNT = 4;
   localparam int TAMPER_BASE   = 4;
   localparam int BTN_OPEN_BIT  = 8;
   localparam int BTN_CLOSE_BIT = 9;

   // reset values of state and registers
   localparam logic [3:0]  DEBOUNCE_RESET    = 4'd3;
   localparam logic [15:0] LEARN_SHORT_RESET = 16'd150;
   localparam logic [15:0] LEARN_RESET_RESET = 16'd500;

   // register indexes
   localparam logic [1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [1:0] CSR_LEARN_SHORT = 2'd1;
   localparam logic [1:0] CSR_LEARN_RESET = 2'd2;

   // event slots in the pending set: contacts first, then open, close, learn
   localparam int SLOT_OPEN  = CONTACT_COUNT;
   localparam int SLOT_CLOSE = CONTACT_COUNT + 1;
   localparam int SLOT_LEARN = CONTACT_COUNT + 2;
   localparam int SLOTS      = CONTACT_COUNT + 3;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CIDX_BITS  = (CONTACT_COUNT > 1) ? $clog2(CONTACT_COUNT) : 1;

   typedef enum logic [2:0] {
      EV_CONTACT = 3'd0,
      EV_STOP    = 3'd1,
      EV_OPEN    = 3'd2,
      EV_CLOSE   = 3'd3,
      EV_LEARN   = 3'd4,
      EV_FACTORY = 3'd5
   } event_kind_type;

   typedef struct packed {
      logic [3:0]  debounce_count;
      logic [15:0] learn_short_ticks;
      logic [15:0] learn_reset_ticks;
   } cfg_type;

   // events caused by one item
   typedef struct packed {
      logic [SLOTS-1:0]         mask;
      logic [CONTACT_COUNT-1:0] closed;
      logic [CONTACT_COUNT-1:0] tamper;
      logic                     open_stop;
      logic                     close_stop;
      logic                     factory;
   } pend_type;

   typedef struct packed {
      logic pend_any;
      logic pop;
      logic pop_last;
   } queue_status_type;

endpackage
`default_nettype wire

/* rtl/diwes_scan.sv */
// debounce state, learn hold counter and event evaluation of one item
`default_nettype none
module diwes_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire diwes_pkg::cfg_type            cfg,
   input  wire logic                          accept,
   input  wire logic [diwes_pkg::WORD_BITS-1:0] raw_word,
   input  wire logic                          learn_level,
   input  wire logic                          shutter_moving,
   input  wire logic                          prime,
   output diwes_pkg::pend_type                events
);
   import diwes_pkg::*;

   logic [WORD_BITS-1:0] stable_ff, stable_in;
   logic [WORD_BITS-1:0] prev_ff, prev_in;
   logic [3:0]           count_ff, count_in;
   logic [15:0]          held_ff, held_in;
   logic                 fired_ff, fired_in;

   logic                 same, settled, changed, open_ev, close_ev, moving2;
   logic                 pressed, learn_ev, factory_ev;
   logic [WORD_BITS-1:0] diff;
   logic [15:0]          held_inc, learn_min;

   // debounce, change and learn hold evaluation
   always_comb begin
      same      = (raw_word == prev_ff);
      settled   = same && !(count_ff < cfg.debounce_count);
      changed   = settled && (raw_word != stable_ff);
      diff      = stable_ff ^ raw_word;
      open_ev   = changed && diff[BTN_OPEN_BIT] && !raw_word[BTN_OPEN_BIT];
      moving2   = shutter_moving || open_ev;
      close_ev  = changed && diff[BTN_CLOSE_BIT] && !raw_word[BTN_CLOSE_BIT];
      pressed   = !learn_level;
      held_inc  = (held_ff == 16'hFFFF) ? held_ff : held_ff + 16'd1;
      learn_min = (cfg.debounce_count == 4'd0) ? 16'd1 : {12'd0, cfg.debounce_count};
      factory_ev = pressed && (held_inc >= cfg.learn_reset_ticks) && !fired_ff;
      learn_ev   = !pressed && (held_ff >= learn_min) &&
                   (held_ff < cfg.learn_short_ticks) && !fired_ff;
   end

   // event set
   always_comb begin
      events = '0;
      for (int i = 0; i < CONTACT_COUNT; i++) begin
         events.mask[i]   = !prime && changed && (diff[i] || diff[TAMPER_BASE + i]);
         events.closed[i] = !raw_word[i];
         events.tamper[i] = raw_word[TAMPER_BASE + i];
      end
      events.mask[SLOT_OPEN]  = !prime && open_ev;
      events.mask[SLOT_CLOSE] = !prime && close_ev;
      events.mask[SLOT_LEARN] = !prime && (factory_ev || learn_ev);
      events.open_stop        = shutter_moving;
      events.close_stop       = moving2;
      events.factory          = pressed;
   end

   // next state
   always_comb begin
      stable_in = stable_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      fired_in  = fired_ff;
      if (prime) begin
         stable_in = raw_word;
         prev_in   = raw_word;
         count_in  = cfg.debounce_count;
      end else begin
         if (!same) begin
            prev_in  = raw_word;
            count_in = 4'd0;
         end else if (count_ff < cfg.debounce_count) begin
            count_in = count_ff + 4'd1;
         end else if (changed) begin
            stable_in = raw_word;
         end
         if (pressed) begin
            held_in  = held_inc;
            fired_in = fired_ff || factory_ev;
         end else begin
            held_in  = 16'd0;
            fired_in = 1'b0;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= '1;
         prev_ff   <= '1;
         count_ff  <= DEBOUNCE_RESET;
         held_ff   <= 16'd0;
         fired_ff  <= 1'b0;
      end else if (accept) begin
         stable_ff <= stable_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         held_ff   <= held_in;
         fired_ff  <= fired_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/diwes_queue.sv */
// pending event set and output register, one event per cycle while rsp_stall is low
`default_nettype none
module diwes_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire diwes_pkg::pend_type     events,
   output logic                         load_stall,
   output diwes_pkg::queue_status_type  status,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_event_kind,
   output logic [1:0]                   rsp_contact_index,
   output logic                         rsp_contact_closed,
   output logic                         rsp_tamper_open,
   output logic                         rsp_last_event
);
   import diwes_pkg::*;

   logic [SLOTS-1:0]         mask_ff, mask_in, rest;
   logic [CONTACT_COUNT-1:0] closed_ff, tamper_ff;
   logic                     open_stop_ff, close_stop_ff, factory_ff;
   logic                     valid_ff;
   logic [2:0]               kind_ff;
   logic [1:0]               index_ff;
   logic                     closed_out_ff, tamper_out_ff, last_ff;

   logic [SLOT_BITS-1:0]     sel;
   logic [CIDX_BITS-1:0]     cidx;
   logic                     found, pop, last;
   event_kind_type           kind;

   // lowest pending slot
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!found && mask_ff[i]) begin
            sel   = SLOT_BITS'(i);
            found = 1'b1;
         end
      end
      rest = mask_ff;
      rest[sel] = 1'b0;
      last = (rest == '0);
      pop  = found && (!valid_ff || !rsp_stall);
      cidx = sel[CIDX_BITS-1:0];
   end

   // event kind of the selected slot
   always_comb begin
      if (sel == SLOT_BITS'(SLOT_OPEN)) begin
         kind = open_stop_ff ? EV_STOP : EV_OPEN;
      end else if (sel == SLOT_BITS'(SLOT_CLOSE)) begin
         kind = close_stop_ff ? EV_STOP : EV_CLOSE;
      end else if (sel == SLOT_BITS'(SLOT_LEARN)) begin
         kind = factory_ff ? EV_FACTORY : EV_LEARN;
      end else begin
         kind = EV_CONTACT;
      end
   end

   // a new item may enter once the pending set drains this cycle
   assign load_stall = found && !(pop && last);

   always_comb begin
      if (load) begin
         mask_in = events.mask;
      end else if (pop) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   // pending set
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         closed_ff     <= events.closed;
         tamper_ff     <= events.tamper;
         open_stop_ff  <= events.open_stop;
         close_stop_ff <= events.close_stop;
         factory_ff    <= events.factory;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind;
         last_ff <= last;
         if (kind == EV_CONTACT) begin
            index_ff      <= 2'(cidx);
            closed_out_ff <= closed_ff[cidx];
            tamper_out_ff <= tamper_ff[cidx];
         end else begin
            index_ff      <= 2'd0;
            closed_out_ff <= 1'b0;
            tamper_out_ff <= 1'b0;
         end
      end
   end

   assign status.pend_any     = found;
   assign status.pop          = pop;
   assign status.pop_last     = last;
   assign rsp_valid           = valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_contact_index   = index_ff;
   assign rsp_contact_closed  = closed_out_ff;
   assign rsp_tamper_open     = tamper_out_ff;
   assign rsp_last_event      = last_ff;

endmodule
`default_nettype wire

/* rtl/debounced_input_word_event_scanner.sv */
// top level of the debounced input word event scanner
// Usage:
//   req channel: one item per scan tick (raw word, learn level, moving flag,
//   prime). Accepted when req_valid is high and req_stall is low.
//   rsp channel: one item per event, in order contacts, open button, close
//   button, learn; rsp_last_event marks the final event of a tick. A tick
//   with no event produces no rsp item.
//   csr port: csr_wr_en writes csr_wdata into register csr_index (0 debounce
//   count, 1 learn short ticks, 2 learn reset ticks); other indexes ignored.
// Path: an event is held in the event set, which loads at the accepting edge,
//   and then in the output register, which drives the rsp item.
// Throughput: the output register takes one event per cycle while rsp_stall
//   is low; a tick has up to seven events, and a new tick is accepted in the
//   cycle the last event of the old one leaves the event set, or at once if none.
// Reset (synchronous, active high): stable and previous words all ones,
//   scan count three, learn counter clear, registers to defaults, no
//   pending events.
// Stall: while rsp_stall holds, the output register keeps its item and
//   req_stall rises as soon as the event set still holds undelivered events.
`default_nettype none
module debounced_input_word_event_scanner (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [diwes_pkg::WORD_BITS-1:0] req_raw_word,
   input  wire logic                          req_learn_level,
   input  wire logic                          req_shutter_moving,
   input  wire logic                          req_prime,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_event_kind,
   output logic [1:0]                         rsp_contact_index,
   output logic                               rsp_contact_closed,
   output logic                               rsp_tamper_open,
   output logic                               rsp_last_event,
   input  wire logic                          csr_wr_en,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [15:0]                   csr_wdata
);
   import diwes_pkg::*;

   cfg_type          cfg_ff;
   pend_type         events;
   queue_status_type status;
   logic             accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count    <= DEBOUNCE_RESET;
         cfg_ff.learn_short_ticks <= LEARN_SHORT_RESET;
         cfg_ff.learn_reset_ticks <= LEARN_RESET_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    cfg_ff.debounce_count    <= csr_wdata[3:0];
            CSR_LEARN_SHORT: cfg_ff.learn_short_ticks <= csr_wdata;
            CSR_LEARN_RESET: cfg_ff.learn_reset_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   diwes_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .accept         (accept),
      .raw_word       (req_raw_word),
      .learn_level    (req_learn_level),
      .shutter_moving (req_shutter_moving),
      .prime          (req_prime),
      .events         (events)
   );

   diwes_queue u_queue (
      .clock              (clock),
      .reset              (reset),
      .load               (accept),
      .events             (events),
      .load_stall         (req_stall),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_contact_index  (rsp_contact_index),
      .rsp_contact_closed (rsp_contact_closed),
      .rsp_tamper_open    (rsp_tamper_open),
      .rsp_last_event     (rsp_last_event)
   );

`ifndef SYNTHESIS
   // an empty event set never holds off a new item
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !status.pend_any |-> !req_stall)
      else $error("req stalled with no pending events");

   // an event that is not the last leaves more events pending
   a_more_after_not_last: assert property (@(posedge clock) disable iff (reset)
      status.pop && !status.pop_last |=> status.pend_any)
      else $error("events lost after a non-final event");

   // every delivered event comes from a pop
   a_rsp_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.pop))
      else $error("rsp item without a popped event");

   // non-contact events carry zero contact fields
   a_noncontact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind != EV_CONTACT) |->
         (rsp_contact_index == 2'd0) && !rsp_contact_closed && !rsp_tamper_open)
      else $error("contact fields set on a non-contact event");
`endif

endmodule
`default_nettype wire
